// ----- rtl/jba_pkg.sv -----
// Package for the JTAG byte command adapter: constants, codes and shared types.
// No dependencies; every module of the block imports it.
package jba_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int Q_DEPTH     = 2;
	localparam int Q_AW        = $clog2(Q_DEPTH);

	localparam logic       MODE_TICK  = 1'b1;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef enum logic [2:0] {
		OP_LED     = 3'd0,
		OP_PINS    = 3'd1,
		OP_RESETS  = 3'd2,
		OP_IOSCAN  = 3'd3,
		OP_OUTSCAN = 3'd4,
		OP_RUNTEST = 3'd5,
		OP_TMSMOVE = 3'd6,
		OP_READTDO = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_PARITY = 2'd1,
		ERR_BUSY   = 2'd2
	} err_t;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_LEN  = 6'b000010,
		PH_DATA = 6'b000100,
		PH_TMSB = 6'b001000,
		PH_LOW  = 6'b010000,
		PH_HIGH = 6'b100000
	} phase_t;

	// Classified input transaction, handed from front to back through the queue
	typedef struct packed {
		logic       tick;
		logic [7:0] data;
		logic       tdo;
		logic       cmd;
		logic       par_odd;
		op_t        op;
		logic [1:0] nlen;
	} item_t;

	typedef struct packed {
		logic led;
		logic srst_n;
		logic trst_n;
		logic tdi;
		logic tms;
		logic tck;
	} pins_t;

	typedef struct packed {
		pins_t      pins;
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic       busy;
		err_t       err;
	} rsp_t;

endpackage

// ----- rtl/jba_cmd_if.sv -----
// Input channel of the adapter: host byte or half-period tick, with TDO level.
// Standalone; valid/ready handshake.
interface jba_cmd_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] host_byte;
	logic       tdo_level;

	modport source (output valid, mode, host_byte, tdo_level, input ready);
	modport sink   (input valid, mode, host_byte, tdo_level, output ready);
endinterface

// ----- rtl/jba_rsp_if.sv -----
// Result channel of the adapter: pin levels, reply byte, busy and error code.
// Standalone; valid/ready handshake.
interface jba_rsp_if;
	logic       valid;
	logic       ready;
	logic       tck_pin;
	logic       tms_pin;
	logic       tdi_pin;
	logic       trst_n_pin;
	logic       srst_n_pin;
	logic       led_on;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic       busy_res;
	logic [1:0] error_code;

	modport source (output valid, tck_pin, tms_pin, tdi_pin, trst_n_pin, srst_n_pin, led_on,
		reply_valid, reply_byte, busy_res, error_code, input ready);
	modport sink   (input valid, tck_pin, tms_pin, tdi_pin, trst_n_pin, srst_n_pin, led_on,
		reply_valid, reply_byte, busy_res, error_code, output ready);
endinterface

// ----- rtl/jba_cfg_if.sv -----
// Configuration write channel of the adapter: the parity check enable bit.
// Standalone; valid/ready handshake.
interface jba_cfg_if;
	logic valid;
	logic ready;
	logic parity_check_enable;

	modport source (output valid, parity_check_enable, input ready);
	modport sink   (input valid, parity_check_enable, output ready);
endinterface

// ----- rtl/jba_front.sv -----
// Front end: accepts input transactions and classifies command bytes.
// Depends on jba_pkg and jba_cmd_if.
module jba_front (
	jba_cmd_if.sink         cmd,
	input  logic            full,
	output logic            push,
	output jba_pkg::item_t  item
);
	import jba_pkg::*;

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	always_comb begin
		item.tick    = (cmd.mode == MODE_TICK);
		item.data    = cmd.host_byte;
		item.tdo     = cmd.tdo_level;
		item.cmd     = cmd.host_byte[7];
		item.par_odd = ^cmd.host_byte;
		item.op      = op_t'(cmd.host_byte[6:4]);
		// count of length bytes flagged in bits 3..1
		item.nlen    = 2'(cmd.host_byte[1]) + 2'(cmd.host_byte[2]) + 2'(cmd.host_byte[3]);
	end
endmodule

// ----- rtl/jba_queue.sv -----
// Short queue between front and back ends, flop based.
// Depends on jba_pkg.
module jba_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jba_pkg::item_t  din,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output jba_pkg::item_t  dout
);
	import jba_pkg::*;

	item_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- rtl/jba_back.sv -----
// Back end: parser and bit clocking engine, one transaction per cycle while the
// result is not stalled, with the result held in an output register. Depends on jba_pkg.
module jba_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            par_en,
	input  logic            empty,
	input  jba_pkg::item_t  it,
	output logic            pop,
	input  logic            rsp_ready,
	output logic            rsp_valid,
	output jba_pkg::rsp_t   rsp
);
	import jba_pkg::*;

	phase_t      phase_q, phase_n;
	op_t         op_q, op_n;
	logic [1:0]  nleft_q, nleft_n;
	len_t        bits_q, bits_n;
	logic [7:0]  oshift_q, oshift_n;
	logic [7:0]  ishift_q, ishift_n;
	logic [3:0]  bib_q, bib_n;
	pins_t       pins_q, pins_n;
	logic        out_valid_q;
	rsp_t        out_q;

	len_t        len_shift, bits_dec;
	logic [3:0]  bib_inc;
	err_t        err;
	logic        rv;
	logic [7:0]  rb;

	function automatic phase_t body_phase(input logic no_bits, input op_t op);
		if (no_bits) begin
			return PH_IDLE;
		end else if (op == OP_RUNTEST) begin
			return PH_LOW;
		end
		return PH_DATA;
	endfunction

	assign pop       = !empty && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		phase_n   = phase_q;
		op_n      = op_q;
		nleft_n   = nleft_q;
		bits_n    = bits_q;
		oshift_n  = oshift_q;
		ishift_n  = ishift_q;
		bib_n     = bib_q;
		pins_n    = pins_q;
		err       = ERR_NONE;
		rv        = 1'b0;
		rb        = '0;
		len_shift = (bits_q << 8) | LENGTH_BITS'(it.data);
		bits_dec  = bits_q - 1'b1;
		bib_inc   = bib_q + 1'b1;

		if (!it.tick) begin
			unique case (phase_q)
				PH_LOW, PH_HIGH: begin
					err = ERR_BUSY;
				end
				PH_LEN: begin
					bits_n  = len_shift;
					nleft_n = nleft_q - 1'b1;
					if (nleft_n == '0) begin
						phase_n = body_phase(len_shift == '0, op_q);
					end
				end
				PH_DATA: begin
					oshift_n = it.data;
					ishift_n = '0;
					bib_n    = '0;
					phase_n  = PH_LOW;
				end
				PH_TMSB: begin
					oshift_n = it.data;
					phase_n  = (bits_q == '0) ? PH_IDLE : PH_LOW;
				end
				default: begin
					// idle, and any code outside the one-hot set
					if (it.cmd) begin
						phase_n = PH_IDLE;
						if (par_en && it.par_odd) begin
							err = ERR_PARITY;
						end else begin
							op_n = it.op;
							unique case (it.op)
								OP_LED: begin
									pins_n.led = it.data[1];
								end
								OP_PINS: begin
									pins_n.tck = it.data[3];
									pins_n.tms = it.data[2];
									pins_n.tdi = it.data[1];
								end
								OP_RESETS: begin
									pins_n.trst_n = it.data[2];
									pins_n.srst_n = it.data[1];
								end
								OP_IOSCAN, OP_OUTSCAN, OP_RUNTEST: begin
									bits_n  = '0;
									nleft_n = it.nlen;
									if (it.nlen == '0) begin
										phase_n = body_phase(1'b1, it.op);
									end else begin
										phase_n = PH_LEN;
									end
								end
								OP_TMSMOVE: begin
									bits_n  = LENGTH_BITS'(it.data[3:1]);
									phase_n = PH_TMSB;
								end
								default: begin
									rv = 1'b1;
									rb = ASCII_ZERO | 8'(it.tdo);
								end
							endcase
						end
					end
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_LOW: begin
					pins_n.tck = 1'b0;
					if (op_q == OP_RUNTEST) begin
						pins_n.tms = 1'b0;
					end else if (op_q == OP_TMSMOVE) begin
						pins_n.tms = oshift_q[0];
						oshift_n   = oshift_q >> 1;
					end else begin
						pins_n.tdi = oshift_q[0];
						pins_n.tms = (bits_q == LENGTH_BITS'(1));
						if (op_q == OP_IOSCAN) begin
							ishift_n[bib_q[2:0]] = ishift_q[bib_q[2:0]] | it.tdo;
						end
						oshift_n = oshift_q >> 1;
					end
					phase_n = PH_HIGH;
				end
				PH_HIGH: begin
					pins_n.tck = 1'b1;
					bits_n     = bits_dec;
					if (op_q == OP_RUNTEST || op_q == OP_TMSMOVE) begin
						phase_n = (bits_dec == '0) ? PH_IDLE : PH_LOW;
					end else begin
						bib_n = bib_inc;
						if (bits_dec == '0 || bib_inc[3]) begin
							if (op_q == OP_IOSCAN) begin
								rv = 1'b1;
								rb = ishift_q;
							end
							phase_n = (bits_dec == '0) ? PH_IDLE : PH_DATA;
						end else begin
							phase_n = PH_LOW;
						end
					end
				end
				default: begin
					// tick while not clocking: no effect
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			op_q        <= OP_LED;
			nleft_q     <= '0;
			bits_q      <= '0;
			oshift_q    <= '0;
			ishift_q    <= '0;
			bib_q       <= '0;
			pins_q      <= '{led: 1'b0, srst_n: 1'b1, trst_n: 1'b1,
				tdi: 1'b0, tms: 1'b0, tck: 1'b0};
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				op_q        <= op_n;
				nleft_q     <= nleft_n;
				bits_q      <= bits_n;
				oshift_q    <= oshift_n;
				ishift_q    <= ishift_n;
				bib_q       <= bib_n;
				pins_q      <= pins_n;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.pins        <= pins_n;
			out_q.reply_valid <= rv;
			out_q.reply_byte  <= rb;
			out_q.busy        <= (phase_n == PH_LOW) || (phase_n == PH_HIGH);
			out_q.err         <= err;
		end
	end
endmodule

// ----- rtl/jtag_byte_command_adapter.sv -----
// JTAG byte command adapter. An accepted input transaction is written into the queue
// and then taken by one back-end step into the result register. Throughput: one
// transaction per cycle through the back-end parser/clocking engine when the result
// is not stalled; a stalled result holds the engine and input ready drops once two
// transactions wait in the queue. Reset (arst_n low, asynchronous): parser
// idle, TCK/TMS/TDI/LED low, TRST_N/SRST_N high, queue and result empty, parity on.
module jtag_byte_command_adapter (
	input  logic       clk,
	input  logic       arst_n,
	jba_cmd_if.sink    cmd,
	jba_cfg_if.sink    cfg,
	jba_rsp_if.source  rsp
);
	import jba_pkg::*;

	// Front to queue
	logic   push;
	item_t  push_item;
	logic   q_full;

	// Queue to back
	logic   q_empty;
	logic   pop;
	item_t  q_item;

	// Configuration register
	logic   par_en_q;

	// Back-end result
	logic   out_valid;
	rsp_t   out_rsp;

	// Take configuration writes at any time; the host only writes while idle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_en_q <= 1'b1;
		end else if (cfg.valid) begin
			par_en_q <= cfg.parity_check_enable;
		end
	end

	// Classify bytes and ticks; stall only when the queue is full
	jba_front u_front (
		.cmd  (cmd),
		.full (q_full),
		.push (push),
		.item (push_item)
	);

	// Decouple acceptance from execution so each side can stall on its own
	jba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.dout   (q_item)
	);

	// Execute one transaction per cycle into the result register unless the result stalls
	jba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.par_en    (par_en_q),
		.empty     (q_empty),
		.it        (q_item),
		.pop       (pop),
		.rsp_ready (rsp.ready),
		.rsp_valid (out_valid),
		.rsp       (out_rsp)
	);

	// Drive the result channel from the registered result
	assign rsp.valid       = out_valid;
	assign rsp.tck_pin     = out_rsp.pins.tck;
	assign rsp.tms_pin     = out_rsp.pins.tms;
	assign rsp.tdi_pin     = out_rsp.pins.tdi;
	assign rsp.trst_n_pin  = out_rsp.pins.trst_n;
	assign rsp.srst_n_pin  = out_rsp.pins.srst_n;
	assign rsp.led_on      = out_rsp.pins.led;
	assign rsp.reply_valid = out_rsp.reply_valid;
	assign rsp.reply_byte  = out_rsp.reply_byte;
	assign rsp.busy_res    = out_rsp.busy;
	assign rsp.error_code  = out_rsp.err;
endmodule

// ----- rtl/jba_checker.sv -----
// Port-level checker for the JTAG byte command adapter, with its bind statement.
// Depends on jba_pkg and the top level jtag_byte_command_adapter.
module jba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       reply_valid,
	input logic [7:0] reply_byte,
	input logic       busy_res,
	input logic [1:0] error_code
);
	import jba_pkg::*;

	// No reply means a zero reply byte
	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !reply_valid |-> reply_byte == 8'h00)
		else $error("reply byte not zero without reply");

	// A byte dropped while clocking leaves the engine clocking
	a_busy_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code == ERR_BUSY |-> busy_res)
		else $error("busy error reported while not busy");

	// A dropped parity-error byte leaves the parser idle with no reply
	a_parity_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code == ERR_PARITY |-> !busy_res && !reply_valid)
		else $error("parity error with busy or reply");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(reply_byte) && $stable(error_code))
		else $error("stalled result changed");
endmodule

bind jtag_byte_command_adapter jba_checker u_jba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.reply_valid (rsp.reply_valid),
	.reply_byte  (rsp.reply_byte),
	.busy_res    (rsp.busy_res),
	.error_code  (rsp.error_code)
);
